// ===== rtl/semaphore_blocked_queue_table_top_assert.svh =====
// Assertion macros for the active semaphore table
`ifndef SEMAPHORE_BLOCKED_QUEUE_TABLE_TOP_ASSERT_SVH
`define SEMAPHORE_BLOCKED_QUEUE_TABLE_TOP_ASSERT_SVH
// Implication checked every clock outside reset
`define SBQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbq check failed");
// Next-cycle implication checked outside reset
`define SBQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbq check failed");
`endif

// ===== rtl/sbq_pkg.sv =====
// Shared types and constants for the active semaphore table
package sbq_pkg;
  localparam int NumProcs = 32;
  localparam int PW = 5;
  localparam int KW = 32;

  typedef enum logic [1:0] {
    KIND_BLOCK  = 2'd0,
    KIND_RMHEAD = 2'd1,
    KIND_RMPROC = 2'd2,
    KIND_PEEK   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_EXEC, ST_LINK, ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic link;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
  } sts_t;
endpackage

// ===== rtl/sbq_ctrl.sv =====
// Operation sequencer for the active semaphore table
module sbq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output sbq_pkg::cmd_t cmd,
  output sbq_pkg::state_t state_o
);
  import sbq_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.lookup = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_LINK;
      end
      ST_LINK: begin
        cmd.link = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign state_o = state;
endmodule

// ===== rtl/sbq_dp.sv =====
// Descriptor table, link memories and result registers
module sbq_dp (
  input  logic                clk,
  input  logic                rst,
  input  sbq_pkg::cmd_t       cmd,
  input  logic [1:0]          kind,
  input  logic [31:0]         sem_key,
  input  logic [4:0]          proc_id,
  output logic                status,
  output logic [4:0]          proc_out,
  output logic                proc_valid
);
  import sbq_pkg::*;

  logic [NumProcs-1:0] blocked;
  logic [NumProcs-1:0] in_use;
  logic [KW-1:0] wait_key [NumProcs];
  logic [PW-1:0] nxt_lnk [NumProcs];
  logic [PW-1:0] prv_lnk [NumProcs];
  logic [KW-1:0] key_st [NumProcs];
  logic [PW-1:0] q_head [NumProcs];
  logic [PW-1:0] q_tail [NumProcs];

  // Latched request
  kind_t         op;
  logic [KW-1:0] key_r;
  logic [PW-1:0] pid_r;
  // Lookup results
  logic          hit;
  logic [PW-1:0] dsc;
  logic          has_free;
  logic [PW-1:0] free_d;
  // Exec results
  logic [PW-1:0] tgt;
  logic [PW-1:0] nx, pv;
  logic          is_h, is_t;
  logic          go;

  // Key compare across all descriptors and free-slot priority pick
  logic [KW-1:0] look_key;
  logic          hit_c, free_c;
  logic [PW-1:0] dsc_c, free_dc;
  always_comb begin
    look_key = (op == KIND_RMPROC) ? wait_key[pid_r] : key_r;
    hit_c = 1'b0; dsc_c = '0; free_c = 1'b0; free_dc = '0;
    for (int d = NumProcs - 1; d >= 0; d--) begin
      if (in_use[d] && key_st[d] == look_key) begin
        hit_c = 1'b1; dsc_c = PW'(d);
      end
      if (!in_use[d]) begin
        free_c = 1'b1; free_dc = PW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= '0;
      in_use  <= '0;
      go      <= 1'b0;
    end else begin
      // Capture the transfer
      if (cmd.load) begin
        op <= kind_t'(kind);
        key_r <= sem_key;
        pid_r <= proc_id;
      end
      // Descriptor search
      if (cmd.lookup) begin
        hit <= hit_c;
        dsc <= dsc_c;
        has_free <= free_c;
        free_d <= free_dc;
      end
      // Decide and update descriptor state
      if (cmd.exec) begin
        go <= 1'b0;
        status <= 1'b1; proc_out <= '0; proc_valid <= 1'b0;
        case (op)
          KIND_BLOCK: begin
            if (!blocked[pid_r] && (hit || has_free)) begin
              status <= 1'b0;
              blocked[pid_r] <= 1'b1;
              wait_key[pid_r] <= key_r;
              nxt_lnk[pid_r] <= pid_r;
              if (!hit) begin
                in_use[free_d] <= 1'b1;
                key_st[free_d] <= key_r;
                q_head[free_d] <= pid_r;
                q_tail[free_d] <= pid_r;
                prv_lnk[pid_r] <= pid_r;
              end else begin
                go <= 1'b1;
                tgt <= q_tail[dsc];
                q_tail[dsc] <= pid_r;
                prv_lnk[pid_r] <= q_tail[dsc];
              end
            end
          end
          KIND_RMHEAD, KIND_RMPROC: begin
            if (hit && (op == KIND_RMHEAD || blocked[pid_r])) begin
              tgt <= (op == KIND_RMHEAD) ? q_head[dsc] : pid_r;
              go <= 1'b1;
              status <= 1'b0; proc_valid <= 1'b1;
              proc_out <= (op == KIND_RMHEAD) ? q_head[dsc] : pid_r;
            end
          end
          default: begin
            if (hit) begin
              status <= 1'b0; proc_valid <= 1'b1; proc_out <= q_head[dsc];
            end
          end
        endcase
      end
      // Link update stage
      if (cmd.link && go) begin
        if (op == KIND_BLOCK) begin
          nxt_lnk[tgt] <= pid_r;
        end else begin
          blocked[tgt] <= 1'b0;
          if (is_h && is_t) in_use[dsc] <= 1'b0;
          else begin
            if (is_h) q_head[dsc] <= nx;
            else nxt_lnk[pv] <= nx;
            if (is_t) q_tail[dsc] <= pv;
            else prv_lnk[nx] <= pv;
          end
        end
      end
    end
  end

  assign nx = nxt_lnk[tgt];
  assign pv = prv_lnk[tgt];
  assign is_h = (q_head[dsc] == tgt);
  assign is_t = (q_tail[dsc] == tgt);
endmodule

// ===== rtl/semaphore_blocked_queue_table_top.sv =====
// Top level of the active semaphore table
//  channel | signals                          | direction
//  in      | in_valid in_stall kind sem_key proc_id | to block
//  out     | out_valid out_stall status proc_out proc_valid | from block
// Each transfer steps through capture, descriptor key search, table update
// and link update; the result is then held until taken.
// One operation at a time; in_stall is high from the cycle after capture
// through the cycle the result transfers, so a new input is not taken until
// the last result has gone. Reset clears all busy and in-use flags.
module semaphore_blocked_queue_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] sem_key,
  input  logic [4:0]  proc_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [4:0]  proc_out,
  output logic        proc_valid
);
  import sbq_pkg::*;
  `include "semaphore_blocked_queue_table_top_assert.svh"

  cmd_t   cmd;
  state_t st;

  sbq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .state_o(st)
  );

  sbq_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(kind), .sem_key(sem_key),
    .proc_id(proc_id), .status(status), .proc_out(proc_out),
    .proc_valid(proc_valid)
  );

  `SBQ_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))
  `SBQ_ASSERT_IMP(a_no_take_busy, out_valid, in_stall)
  `SBQ_ASSERT_IMP(a_valid_ok, out_valid && proc_valid, !status)
  `SBQ_ASSERT_NXT(a_load_seq, cmd.load, cmd.lookup)
  `SBQ_ASSERT_IMP(a_out_state, out_valid, st == ST_OUT)
endmodule

// ===== dv/semaphore_blocked_queue_table_top_tb.sv =====
// Testbench for the active semaphore table: directed and random operations, scoreboard check
`timescale 1ns / 1ps
module semaphore_blocked_queue_table_top_tb;
  import sbq_pkg::*;

  typedef struct packed {
    logic       status;
    logic [4:0] proc_out;
    logic       proc_valid;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_PEEK;
  logic [31:0] sem_key = 32'd1;
  logic [4:0]  proc_id = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [4:0]  proc_out;
  logic        proc_valid;

  semaphore_blocked_queue_table_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the semaphore table
  logic        blocked_q[NumProcs];
  logic [31:0] wait_key_q[NumProcs];
  logic [4:0]  next_q[NumProcs];
  logic [4:0]  prev_q[NumProcs];
  logic        desc_used[NumProcs];
  logic [31:0] desc_key[NumProcs];
  logic [4:0]  desc_head[NumProcs];
  logic [4:0]  desc_tail[NumProcs];

  answer_t pending_answers[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;
  logic [31:0] key_pool[6];

  function automatic int lookup_desc(logic [31:0] k);
    for (int d = 0; d < NumProcs; d++)
      if (desc_used[d] && desc_key[d] == k) return d;
    return -1;
  endfunction

  function automatic void unlink(int d, logic [4:0] p);
    logic [4:0] nx;
    logic [4:0] pv;
    logic hd;
    logic tl;
    nx = next_q[p];
    pv = prev_q[p];
    hd = (desc_head[d] == p);
    tl = (desc_tail[d] == p);
    if (hd && tl) begin
      desc_used[d] = 1'b0;
    end else begin
      if (hd) desc_head[d] = nx;
      else next_q[pv] = nx;
      if (tl) desc_tail[d] = pv;
      else prev_q[nx] = pv;
    end
    blocked_q[p] = 1'b0;
  endfunction

  // Work out the answer to one operation and update the shadow table
  function automatic answer_t apply_operation(kind_t k, logic [31:0] key, logic [4:0] p);
    answer_t a;
    int d;
    a = '{status: 1'b1, proc_out: 5'd0, proc_valid: 1'b0};
    case (k)
      KIND_BLOCK: begin
        if (!blocked_q[p]) begin
          d = lookup_desc(key);
          if (d < 0) begin
            for (d = 0; d < NumProcs; d++)
              if (!desc_used[d]) break;
            if (d < NumProcs) begin
              desc_used[d] = 1'b1;
              desc_key[d] = key;
              desc_head[d] = p;
              prev_q[p] = p;
            end
          end else begin
            next_q[desc_tail[d]] = p;
            prev_q[p] = desc_tail[d];
          end
          if (d < NumProcs) begin
            desc_tail[d] = p;
            next_q[p] = p;
            wait_key_q[p] = key;
            blocked_q[p] = 1'b1;
            a.status = 1'b0;
          end
        end
      end
      KIND_RMHEAD: begin
        d = lookup_desc(key);
        if (d >= 0) begin
          a = '{status: 1'b0, proc_out: desc_head[d], proc_valid: 1'b1};
          unlink(d, desc_head[d]);
        end
      end
      KIND_RMPROC: begin
        if (blocked_q[p]) begin
          d = lookup_desc(wait_key_q[p]);
          if (d >= 0) begin
            unlink(d, p);
            a = '{status: 1'b0, proc_out: p, proc_valid: 1'b1};
          end
        end
      end
      default: begin
        d = lookup_desc(key);
        if (d >= 0) a = '{status: 1'b0, proc_out: desc_head[d], proc_valid: 1'b1};
      end
    endcase
    return a;
  endfunction

  // Offer one operation and wait for its transfer
  task automatic send_op(kind_t k, logic [31:0] key, logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sem_key <= key;
    proc_id <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(apply_operation(k, key, p));
  endtask

  // Receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_a = pending_answers.pop_front();
        if (exp_a.status !== status || exp_a.proc_out !== proc_out ||
            exp_a.proc_valid !== proc_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %b/%0d/%b got %b/%0d/%b", exp_a.status,
                     exp_a.proc_out, exp_a.proc_valid, status, proc_out, proc_valid);
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom() | 32'd1;
    return key_pool[$urandom_range(5)];
  endfunction

  // Field extremes, every operation, refusals and not-found cases
  task automatic test_directed();
    send_op(KIND_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_RMHEAD, 32'd1, 5'd0);
    send_op(KIND_RMPROC, 32'd1, 5'd31);
    send_op(KIND_BLOCK, 32'd1, 5'd0);
    send_op(KIND_BLOCK, 32'd1, 5'd31);
    send_op(KIND_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_op(KIND_BLOCK, 32'd1, 5'd5);
    send_op(KIND_PEEK, 32'd1, 5'd0);
    send_op(KIND_RMPROC, 32'd0, 5'd31);
    send_op(KIND_RMHEAD, 32'd1, 5'd0);
    send_op(KIND_PEEK, 32'd1, 5'd0);
    send_op(KIND_RMHEAD, 32'd1, 5'd0);
    send_op(KIND_PEEK, 32'd1, 5'd0);
    send_op(KIND_RMPROC, 32'd0, 5'd5);
  endtask

  // All 32 processes on distinct keys fills the table, then drain
  task automatic test_full_table();
    for (int i = 0; i < NumProcs; i++) send_op(KIND_BLOCK, 32'h100 + i, i[4:0]);
    send_op(KIND_BLOCK, 32'hFFFF_FFFF, 5'd3);
    for (int i = 0; i < NumProcs; i++) send_op(KIND_RMPROC, 32'h0, i[4:0]);
  endtask

  // Random operations biased toward a small key pool
  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      send_op(r < 4 ? KIND_BLOCK : r < 6 ? KIND_RMHEAD : r < 8 ? KIND_RMPROC : KIND_PEEK,
              pick_key(), 5'($urandom_range(31)));
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 200;
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < NumProcs; i++) begin
      blocked_q[i] = 1'b0;
      desc_used[i] = 1'b0;
    end
    for (int i = 0; i < 6; i++) key_pool[i] = $urandom() | 32'd1;
    key_pool[0] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 54;
    test_directed();
    test_full_table();
    test_random(130);
    send_idle_pct = 54;
    recv_idle_pct = 38;
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(100);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== semaphore_blocked_queue_table_top.f =====
+incdir+rtl
rtl/sbq_pkg.sv
rtl/sbq_ctrl.sv
rtl/sbq_dp.sv
rtl/semaphore_blocked_queue_table_top.sv
dv/semaphore_blocked_queue_table_top_tb.sv
